>>> sv/farthest_point_sampler_macros.svh
// Assertion macros used by the sampler top level.
`ifndef FARTHEST_POINT_SAMPLER_MACROS_SVH
`define FARTHEST_POINT_SAMPLER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define FPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define FPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> sv/fps_pkg.sv
// Shared types and constants of the farthest point sampler.
package fps_pkg;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned ORDER_W = 6;
    localparam int unsigned CNT_W   = 7;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLEAR = 7'b0000010,
        ST_EMIT  = 7'b0000100,
        ST_UPD   = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_PICK  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // write input point at the fill count
        logic run_init;  // latch run parameters
        logic clr_step;  // clear one chosen flag
        logic mark;      // set chosen flag of the current pick, emit it
        logic upd_start; // begin an update sweep
        logic scan_start;// begin a search sweep
        logic pick;      // adopt the search winner
        logic finish;    // empty the store
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clr_done;
        logic upd_done;
        logic scan_done;
        logic run_empty;
        logic run_last;
        logic out_busy;
    } stat_t;
endpackage

>>> sv/fps_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module fps_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/fps_ctrl.sv
// Run sequencer of the farthest point sampler.
module fps_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic           in_action,
    output logic           in_rdy,
    input  fps_pkg::stat_t stat,
    output fps_pkg::cmd_t  cmd
);
    fps_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_rdy     = 1'b0;
        unique case (state_reg)
            fps_pkg::ST_IDLE:
            begin
                in_rdy = 1'b1;
                if (in_fire)
                begin
                    if (!in_action)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.run_init = 1'b1;
                        state_next   = fps_pkg::ST_CLEAR;
                    end
                end
            end
            fps_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = stat.run_empty ? fps_pkg::ST_DONE : fps_pkg::ST_EMIT;
                end
            end
            fps_pkg::ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.mark = 1'b1;
                    if (stat.run_last)
                    begin
                        state_next = fps_pkg::ST_DONE;
                    end
                    else
                    begin
                        cmd.upd_start = 1'b1;
                        state_next    = fps_pkg::ST_UPD;
                    end
                end
            end
            fps_pkg::ST_UPD:
            begin
                if (stat.upd_done)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = fps_pkg::ST_SCAN;
                end
            end
            fps_pkg::ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = fps_pkg::ST_PICK;
                end
            end
            fps_pkg::ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = fps_pkg::ST_EMIT;
            end
            fps_pkg::ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = fps_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fps_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

>>> sv/fps_datapath.sv
// Point storage, distance update sweep, farthest search sweep and output register.
module fps_datapath #(
    parameter int unsigned MAX_POINTS  = 1024,
    parameter int unsigned MAX_SAMPLES = 64,
    parameter int unsigned COORD_WIDTH = 16,
    parameter int unsigned DIMS        = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fps_pkg::cmd_t                 cmd,
    output fps_pkg::stat_t                stat,
    input  logic signed [15:0]            coord_x,
    input  logic signed [15:0]            coord_y,
    input  logic signed [15:0]            coord_z,
    input  logic [fps_pkg::IDX_W-1:0]     start_index,
    input  logic [fps_pkg::CNT_W-1:0]     sample_count,
    output logic [fps_pkg::IDX_W-1:0]     sample_index,
    output logic [fps_pkg::ORDER_W-1:0]   sample_order,
    output logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready
);
    localparam int unsigned AW     = $clog2(MAX_POINTS);
    localparam int unsigned NW     = $clog2(MAX_POINTS + 1);
    localparam int unsigned ND     = (DIMS > 3) ? 3 : DIMS;
    localparam int unsigned PW     = COORD_WIDTH * ND;
    localparam int unsigned DW     = COORD_WIDTH + 1;
    localparam int unsigned SQW    = 2 * DW;
    localparam int unsigned DSTW   = SQW + 2;
    localparam int unsigned MW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES + 1) : 1;
    localparam int unsigned CW_CNT = fps_pkg::CNT_W;

    logic [NW-1:0] count_reg;
    logic [AW-1:0] cur_reg;
    logic [MW-1:0] m_reg, j_reg;
    logic first_reg;

    // Coordinates of the current pick, fetched once per update sweep.
    logic [PW-1:0] cur_pt_reg;

    // Point memory: port read address is muxed between sweeps.
    logic [AW-1:0] p_raddr;
    logic [PW-1:0] p_rdata, p_wdata;
    // Distance memory entries hold the chosen flag above the nearest distance.
    logic [AW-1:0] d_raddr, d_waddr;
    logic [DSTW:0] d_rdata, d_wdata;
    logic d_we;
    logic d_chosen;
    logic [DSTW-1:0] d_dist;

    // Sweep pipeline: issue index, stage 1 (read data), stage 2 (squares), stage 3 (write).
    logic upd_act_reg, scan_act_reg, fetch_reg;
    logic [NW-1:0] k_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic [AW-1:0] a1_reg, a2_reg, a3_reg;
    logic [SQW-1:0] sq_reg [ND];
    logic [DSTW-1:0] old2_reg, dist3_reg;
    logic best_have_reg;
    logic [AW-1:0] best_reg;
    logic [DSTW-1:0] best_d_reg;
    logic clr_busy_reg;
    logic [CW_CNT-1:0] m_clamp;

    always_comb
    begin
        p_wdata = '0;
        p_wdata[COORD_WIDTH-1:0] = coord_x[COORD_WIDTH-1:0];
        if (ND > 1)
        begin
            p_wdata[COORD_WIDTH +: COORD_WIDTH] = coord_y[COORD_WIDTH-1:0];
        end
        if (ND > 2)
        begin
            p_wdata[(ND-1)*COORD_WIDTH +: COORD_WIDTH] = coord_z[COORD_WIDTH-1:0];
        end
    end

    fps_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pts (
        .clk   (clk),
        .we    (cmd.load && (count_reg < NW'(MAX_POINTS))),
        .waddr (count_reg[AW-1:0]),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    fps_ram #(.WIDTH(DSTW + 1), .DEPTH(MAX_POINTS)) u_dist (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    assign d_chosen = d_rdata[DSTW];
    assign d_dist   = d_rdata[DSTW-1:0];

    logic issue;
    assign issue   = (upd_act_reg || scan_act_reg) && !fetch_reg && (k_reg < count_reg);
    assign p_raddr = fetch_reg ? cur_reg : k_reg[AW-1:0];
    assign d_raddr = k_reg[AW-1:0];

    // Stage 2 squared differences against the current pick.
    logic [SQW-1:0] sq_next [ND];
    always_comb
    begin
        for (int d = 0; d < ND; d++)
        begin
            logic signed [DW-1:0] diff;
            logic [DW-1:0] mag;
            diff = DW'($signed(p_rdata[d*COORD_WIDTH +: COORD_WIDTH]))
                 - DW'($signed(cur_pt_reg[d*COORD_WIDTH +: COORD_WIDTH]));
            mag  = diff[DW-1] ? DW'(-diff) : diff;
            sq_next[d] = SQW'(mag) * SQW'(mag);
        end
    end

    logic [DSTW-1:0] sum3;
    always_comb
    begin
        sum3 = '0;
        for (int d = 0; d < ND; d++)
        begin
            sum3 = sum3 + DSTW'(sq_reg[d]);
        end
    end

    logic keep_new;
    assign keep_new = first_reg || (sum3 < old2_reg);

    // The clearing pass, the mark of a pick and the update write never overlap.
    always_comb
    begin
        d_we    = 1'b0;
        d_waddr = a3_reg;
        d_wdata = {1'b0, dist3_reg};
        if (cmd.clr_step)
        begin
            d_we    = 1'b1;
            d_waddr = k_reg[AW-1:0];
            d_wdata = '0;
        end
        else if (cmd.mark)
        begin
            d_we    = 1'b1;
            d_waddr = cur_reg;
            d_wdata = {1'b1, {DSTW{1'b0}}};
        end
        else if (v3_reg)
        begin
            d_we = 1'b1;
        end
    end

    always_comb
    begin
        m_clamp = sample_count;
        if (NW'(sample_count) > count_reg) m_clamp = CW_CNT'(count_reg);
        if (m_clamp > CW_CNT'(MAX_SAMPLES)) m_clamp = CW_CNT'(MAX_SAMPLES);
    end

    logic pipe_empty;
    assign pipe_empty = !v1_reg && !v2_reg && !v3_reg && !issue && !fetch_reg;

    assign stat.clr_done  = clr_busy_reg && (k_reg == NW'(MAX_POINTS - 1));
    assign stat.upd_done  = upd_act_reg && pipe_empty;
    assign stat.scan_done = scan_act_reg && !issue && !v1_reg;
    assign stat.run_empty = (m_reg == '0);
    assign stat.run_last  = (j_reg + MW'(1) == m_reg);
    assign stat.out_busy  = out_valid && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cur_reg       <= '0;
            m_reg         <= '0;
            j_reg         <= '0;
            first_reg     <= 1'b0;
            upd_act_reg   <= 1'b0;
            scan_act_reg  <= 1'b0;
            fetch_reg     <= 1'b0;
            k_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            a1_reg        <= '0;
            a2_reg        <= '0;
            a3_reg        <= '0;
            old2_reg      <= '0;
            dist3_reg     <= '0;
            for (int d = 0; d < ND; d++)
            begin
                sq_reg[d] <= '0;
            end
            best_have_reg <= 1'b0;
            best_reg      <= '0;
            best_d_reg    <= '0;
            clr_busy_reg  <= 1'b0;
            out_valid     <= 1'b0;
            sample_index  <= '0;
            sample_order  <= '0;
            last          <= 1'b0;
        end
        else
        begin
            if (cmd.mark)
            begin
                out_valid    <= 1'b1;
                sample_index <= fps_pkg::IDX_W'(cur_reg);
                sample_order <= fps_pkg::ORDER_W'(j_reg);
                last         <= stat.run_last;
            end
            else if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            if (cmd.load && (count_reg < NW'(MAX_POINTS)))
            begin
                count_reg <= count_reg + NW'(1);
            end
            if (cmd.run_init)
            begin
                m_reg <= MW'(m_clamp);
                if (NW'(start_index) >= count_reg)
                begin
                    cur_reg <= AW'(count_reg - NW'(1));
                end
                else
                begin
                    cur_reg <= AW'(start_index);
                end
                j_reg        <= '0;
                first_reg    <= 1'b1;
                k_reg        <= '0;
                clr_busy_reg <= 1'b1;
            end
            if (cmd.clr_step)
            begin
                k_reg <= k_reg + NW'(1);
                if (stat.clr_done)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cmd.upd_start)
            begin
                upd_act_reg <= 1'b1;
                fetch_reg   <= 1'b1;
                k_reg       <= '0;
            end
            if (fetch_reg)
            begin
                fetch_reg <= 1'b0;
            end
            if (cmd.scan_start)
            begin
                scan_act_reg  <= 1'b1;
                k_reg         <= '0;
                best_have_reg <= 1'b0;
                first_reg     <= 1'b0;
            end
            if (issue)
            begin
                k_reg <= k_reg + NW'(1);
            end
            v1_reg <= issue;
            a1_reg <= k_reg[AW-1:0];
            v2_reg <= v1_reg && upd_act_reg && !d_chosen;
            a2_reg <= a1_reg;
            old2_reg <= d_dist;
            for (int d = 0; d < ND; d++)
            begin
                sq_reg[d] <= sq_next[d];
            end
            v3_reg    <= v2_reg;
            a3_reg    <= a2_reg;
            dist3_reg <= keep_new ? sum3 : old2_reg;
            if (stat.upd_done)
            begin
                upd_act_reg <= 1'b0;
            end
            if (scan_act_reg && v1_reg && !d_chosen)
            begin
                if (!best_have_reg || d_dist > best_d_reg)
                begin
                    best_have_reg <= 1'b1;
                    best_reg      <= a1_reg;
                    best_d_reg    <= d_dist;
                end
            end
            if (stat.scan_done)
            begin
                scan_act_reg <= 1'b0;
            end
            if (cmd.pick)
            begin
                cur_reg <= best_reg;
                j_reg   <= j_reg + MW'(1);
            end
            if (cmd.finish)
            begin
                count_reg <= '0;
            end
        end
    end

    // Current point coordinates arrive in the cycle after the fetch read.
    logic fetch_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_d_reg <= 1'b0;
        end
        else
        begin
            fetch_d_reg <= fetch_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fetch_d_reg)
        begin
            cur_pt_reg <= p_rdata;
        end
    end
endmodule

>>> sv/farthest_point_sampler.sv
// A load is accepted while idle; a run first clears MAX_POINTS chosen flags before
// its first sample is valid. Each further sample costs an update sweep and a search
// sweep over the stored points, then a pick step and an emit step.
// Throughput: loads one per cycle while idle; a run holds the block until its last
// sample is marked, and longer while the output stalls.
// Reset: asynchronous active low; empties the store and clears control state.
`include "farthest_point_sampler_macros.svh"
module farthest_point_sampler #(
    parameter int unsigned MAX_POINTS  = 1024,
    parameter int unsigned MAX_SAMPLES = 64,
    parameter int unsigned COORD_WIDTH = 16,
    parameter int unsigned DIMS        = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        action,
    input  logic signed [15:0]          coord_x,
    input  logic signed [15:0]          coord_y,
    input  logic signed [15:0]          coord_z,
    input  logic [9:0]                  start_index,
    input  logic [6:0]                  sample_count,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [9:0]                  sample_index,
    output logic [5:0]                  sample_order,
    output logic                        last
);
    fps_pkg::cmd_t  cmd;
    fps_pkg::stat_t stat;
    logic in_fire;

    assign in_fire = in_valid && in_ready;

    fps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_action (action),
        .in_rdy    (in_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fps_datapath #(
        .MAX_POINTS  (MAX_POINTS),
        .MAX_SAMPLES (MAX_SAMPLES),
        .COORD_WIDTH (COORD_WIDTH),
        .DIMS        (DIMS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .start_index  (start_index),
        .sample_count (sample_count),
        .sample_index (sample_index),
        .sample_order (sample_order),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

    `FPS_ASSERT_IMP(a_mark_free, cmd.mark, !(out_valid && !out_ready), "result overwritten")
    `FPS_ASSERT_IMP(a_one_cmd, 1'b1, $countones({cmd.load, cmd.run_init, cmd.pick, cmd.finish}) <= 1, "conflicting commands")
    `FPS_ASSERT_NEXT(a_finish_idle, cmd.finish, in_ready, "not idle after run")
endmodule

>>> bench/tb_farthest_point_sampler.sv
// Self-checking testbench for the farthest point sampler.
`timescale 1ns / 1ps

module tb_farthest_point_sampler;
    localparam int unsigned STORE_DEPTH = 1024;
    localparam int unsigned SAMPLE_CAP  = 64;
    localparam bit ACT_LOAD = 1'b0;
    localparam bit ACT_RUN  = 1'b1;

    typedef struct {
        bit                        action;
        logic signed [15:0]        x;
        logic signed [15:0]        y;
        logic signed [15:0]        z;
        logic [fps_pkg::IDX_W-1:0] start;
        logic [fps_pkg::CNT_W-1:0] count;
    } request_t;

    typedef struct {
        logic [fps_pkg::IDX_W-1:0]   index;
        logic [fps_pkg::ORDER_W-1:0] order;
        logic                        last;
    } sample_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic action;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [fps_pkg::IDX_W-1:0] start_index;
    logic [fps_pkg::CNT_W-1:0] sample_count;
    logic out_valid;
    logic out_ready;
    logic [fps_pkg::IDX_W-1:0] sample_index;
    logic [fps_pkg::ORDER_W-1:0] sample_order;
    logic last;

    request_t pending_requests[$];
    sample_t  expected_samples[$];

    // Software copy of the loaded cloud.
    int cloud_x[STORE_DEPTH];
    int cloud_y[STORE_DEPTH];
    int cloud_z[STORE_DEPTH];
    int cloud_size;

    int error_count;
    int loads_sent;
    int runs_sent;
    int samples_checked;
    int gap_left;
    int hold_left;
    bit hold_done;
    bit stimulus_ready;

    farthest_point_sampler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .start_index  (start_index),
        .sample_count (sample_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_index (sample_index),
        .sample_order (sample_order),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Greedy farthest point selection over the current cloud; empties the cloud.
    function automatic void sample_cloud(input request_t req);
        int n;
        int m;
        int pick;
        int best;
        bit have;
        bit taken[STORE_DEPTH];
        longint unsigned nearest[STORE_DEPTH];
        longint unsigned far_gap;
        longint unsigned sq_gap;
        longint dx;
        longint dy;
        longint dz;
        sample_t s;
        n = cloud_size;
        m = req.count;
        if (m > n)
            m = n;
        if (m > SAMPLE_CAP)
            m = SAMPLE_CAP;
        for (int k = 0; k < STORE_DEPTH; k++)
        begin
            taken[k] = 1'b0;
            nearest[k] = 0;
        end
        if (m > 0)
        begin
            pick = req.start;
            if (pick >= n)
                pick = n - 1;
            for (int j = 0; j < m; j++)
            begin
                if (j > 0)
                begin
                    have = 1'b0;
                    best = 0;
                    far_gap = 0;
                    for (int k = 0; k < n; k++)
                    begin
                        if (!taken[k] && (!have || nearest[k] > far_gap))
                        begin
                            have = 1'b1;
                            best = k;
                            far_gap = nearest[k];
                        end
                    end
                    pick = best;
                end
                taken[pick] = 1'b1;
                for (int k = 0; k < n; k++)
                begin
                    if (!taken[k])
                    begin
                        dx = longint'(cloud_x[k]) - longint'(cloud_x[pick]);
                        dy = longint'(cloud_y[k]) - longint'(cloud_y[pick]);
                        dz = longint'(cloud_z[k]) - longint'(cloud_z[pick]);
                        sq_gap = dx * dx + dy * dy + dz * dz;
                        if (j == 0 || sq_gap < nearest[k])
                            nearest[k] = sq_gap;
                    end
                end
                s.index = pick[fps_pkg::IDX_W-1:0];
                s.order = j[fps_pkg::ORDER_W-1:0];
                s.last  = (j + 1 == m);
                expected_samples.insert(expected_samples.size(), s);
            end
        end
        cloud_size = 0;
    endfunction

    function automatic void add_load(input int x, input int y, input int z);
        request_t r;
        r.action = ACT_LOAD;
        r.x = x[15:0];
        r.y = y[15:0];
        r.z = z[15:0];
        r.start = fps_pkg::IDX_W'($urandom);
        r.count = fps_pkg::CNT_W'($urandom);
        pending_requests.insert(pending_requests.size(), r);
    endfunction

    function automatic void add_run(input int start, input int count);
        request_t r;
        r.action = ACT_RUN;
        r.x = 16'($urandom);
        r.y = 16'($urandom);
        r.z = 16'($urandom);
        r.start = start[fps_pkg::IDX_W-1:0];
        r.count = count[fps_pkg::CNT_W-1:0];
        pending_requests.insert(pending_requests.size(), r);
    endfunction

    // Random cloud followed by a run; narrow coordinate spans produce ties.
    function automatic void add_cloud(input int points, input int span);
        int lo;
        int hi;
        lo = -span;
        hi = span - 1;
        for (int i = 0; i < points; i++)
            add_load($urandom_range(0, hi - lo) + lo, $urandom_range(0, hi - lo) + lo,
                     $urandom_range(0, hi - lo) + lo);
        if ($urandom_range(0, 3) == 0)
            add_run($urandom_range(0, STORE_DEPTH - 1), $urandom_range(0, 127));
        else
            add_run($urandom_range(0, points), $urandom_range(1, points + 2));
    endfunction

    // Driver: records every accepted load, predicts every accepted run, then offers the next request.
    always @(posedge clk or negedge rst_n)
    begin
        request_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= ACT_LOAD;
            coord_x <= '0;
            coord_y <= '0;
            coord_z <= '0;
            start_index <= '0;
            sample_count <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (action == ACT_LOAD)
                begin
                    loads_sent <= loads_sent + 1;
                    if (cloud_size < STORE_DEPTH)
                    begin
                        cloud_x[cloud_size] = int'(coord_x);
                        cloud_y[cloud_size] = int'(coord_y);
                        cloud_z[cloud_size] = int'(coord_z);
                        cloud_size = cloud_size + 1;
                    end
                end
                else
                begin
                    runs_sent <= runs_sent + 1;
                    r.action = action;
                    r.start = start_index;
                    r.count = sample_count;
                    sample_cloud(r);
                end
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (stimulus_ready && pending_requests.size() > 0)
                begin
                    r = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    action <= r.action;
                    coord_x <= r.x;
                    coord_y <= r.y;
                    coord_z <= r.z;
                    start_index <= r.start;
                    sample_count <= r.count;
                    if (pending_requests.size() > 40 && $urandom_range(0, 4) == 0)
                        gap_left <= $urandom_range(1, 11);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts plus one long hold-off while requests queue up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && runs_sent >= 6 && out_valid)
        begin
            out_ready <= 1'b0;
            hold_left <= 3000;
            hold_done <= 1'b1;
        end
        else if (pending_requests.size() > 40 && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            hold_left <= $urandom_range(1, 11);
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: checks every accepted sample against the oldest prediction.
    always @(posedge clk)
    begin
        sample_t want;
        int errs;
        errs = 0;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("unexpected sample: index %0d order %0d", sample_index, sample_order);
                errs = errs + 1;
            end
            else
            begin
                want = expected_samples.pop_front();
                samples_checked <= samples_checked + 1;
                if (sample_index !== want.index)
                begin
                    $error("sample_index: expected %0d, got %0d", want.index, sample_index);
                    errs = errs + 1;
                end
                if (sample_order !== want.order)
                begin
                    $error("sample_order: expected %0d, got %0d", want.order, sample_order);
                    errs = errs + 1;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    errs = errs + 1;
                end
            end
            if (errs > 0)
                error_count <= error_count + errs;
        end
    end

    initial
    begin
        #5_000_000;
        $display("farthest_point_sampler test failed");
        $finish;
    end

    initial
    begin
        error_count = 0;
        loads_sent = 0;
        runs_sent = 0;
        samples_checked = 0;
        cloud_size = 0;
        stimulus_ready = 1'b0;
        rst_n = 1'b0;

        // Directed: empty cloud, coordinate extremes, clamped start, capped count.
        add_run(0, 5);
        add_load(-32768, -32768, -32768);
        add_load(32767, 32767, 32767);
        add_load(0, 0, 0);
        add_load(32767, -32768, 0);
        add_run(1023, 127);
        // Duplicate points: all ties resolve to the lowest unchosen index.
        add_load(7, 7, 7);
        add_load(7, 7, 7);
        add_load(7, 7, 7);
        add_run(1, 3);
        // Zero count empties the store; the following run sees an empty cloud.
        add_load(1, 2, 3);
        add_load(-1, -2, -3);
        add_run(0, 0);
        add_run(0, 64);
        add_load(100, -200, 300);
        add_run(0, 1);

        // Random clouds, mostly small, some with narrow spans for ties.
        for (int i = 0; i < 7; i++)
            add_cloud($urandom_range(1, 20), ($urandom_range(0, 1) != 0) ? 32768 : 3);
        for (int i = 0; i < 8; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                add_run($urandom_range(0, STORE_DEPTH - 1), $urandom_range(0, 127));
            else
                add_cloud($urandom_range(1, 16), ($urandom_range(0, 2) != 0) ? 32768 : 2);
        end
        // A cloud larger than the sample cap can exercise the full 64-sample run.
        add_cloud(70, 32768);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        stimulus_ready <= 1'b1;

        wait (pending_requests.size() == 0 && !in_valid);
        wait (expected_samples.size() == 0);
        repeat (1500) @(posedge clk);

        $display("Covered %0d point loads and %0d sampling runs; %0d samples compared.",
                 loads_sent, runs_sent, samples_checked);
        if (error_count == 0 && expected_samples.size() == 0)
            $display("farthest_point_sampler test passed");
        else
            $display("farthest_point_sampler test failed");
        $finish;
    end

endmodule
